// ----- src/gbp_pkg.sv -----
package gbp_pkg;

  // Cell values
  localparam logic [24:0] V_BLOCKED = 25'd1000000;
  localparam logic [24:0] V_SEED    = 25'd1100100;
  localparam logic [24:0] V_STEP    = 25'd100000;
  localparam logic [24:0] V_FLOOR   = 25'd10;
  localparam logic [24:0] V_REACH   = 25'd1;

  // Request modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_START_X  = 3'd0;
  localparam logic [2:0] CFG_START_Y  = 3'd1;
  localparam logic [2:0] CFG_GOAL_X   = 3'd2;
  localparam logic [2:0] CFG_GOAL_Y   = 3'd3;
  localparam logic [2:0] CFG_EXTENT_X = 3'd4;
  localparam logic [2:0] CFG_EXTENT_Y = 3'd5;

  // Neighbour offsets, in visit order
  localparam logic [1:0] NB_DX [8] = '{2'b11, 2'b11, 2'b11, 2'b00, 2'b00, 2'b01, 2'b01, 2'b01};
  localparam logic [1:0] NB_DY [8] = '{2'b11, 2'b00, 2'b01, 2'b11, 2'b01, 2'b11, 2'b00, 2'b01};

  // Datapath commands from the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLR_STEP,   // write zero at clear address, advance clear pointer
    CMD_WR_CELL,    // write request cell
    CMD_RD_CELL,    // issue read of request cell
    CMD_CLR_SG,     // write zero to start or goal (sel)
    CMD_Q_RESET,    // reset queue and scan pointers
    CMD_PUSH_START, // push start cell
    CMD_POP,        // issue read of queue head
    CMD_LOAD_CUR,   // latch popped address, issue grid read of it
    CMD_LOAD_PV,    // latch parent value
    CMD_NB_RD,      // issue grid read of neighbour
    CMD_NB_UPD,     // evaluate neighbour, write and push
    CMD_SCAN_RD,    // issue grid read at scan pointer
    CMD_SCAN_UPD    // evaluate scanned cell, advance scan pointer
  } gbp_cmd_t;

  typedef struct packed {
    gbp_cmd_t   cmd;
    logic       sel;    // goal when set for clear, wavefront when set for updates
    logic [2:0] nb;
  } gbp_ctl_t;

  typedef struct packed {
    logic clr_last;
    logic q_empty;
    logic nb_ok;
    logic scan_last;
  } gbp_sts_t;

endpackage

// ----- src/gbp_if.sv -----
interface gbp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] cell_x;
  logic [7:0] cell_y;
  logic       blocked;
  modport source (output valid, mode, cell_x, cell_y, blocked, input ready);
  modport sink (input valid, mode, cell_x, cell_y, blocked, output ready);
endinterface

interface gbp_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] cell_value;
  logic        done_res;
  modport source (output valid, cell_value, done_res, input ready);
  modport sink (input valid, cell_value, done_res, output ready);
endinterface

// ----- src/gbp_ram.sv -----
module gbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/gbp_datapath.sv -----
module gbp_datapath #(
  parameter int GRID_SIDE = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gbp_pkg::gbp_ctl_t ctl,
  output gbp_pkg::gbp_sts_t sts,
  input  logic [7:0]      req_x,
  input  logic [7:0]      req_y,
  input  logic            req_blk,
  input  logic [7:0]      start_x,
  input  logic [7:0]      start_y,
  input  logic [7:0]      goal_x,
  input  logic [7:0]      goal_y,
  input  logic [7:0]      extent_x,
  input  logic [7:0]      extent_y,
  output logic [24:0]     rd_value
);
  localparam int CW = $clog2(GRID_SIDE);
  localparam int AW = 2 * CW;
  localparam int QW = AW + 1;
  localparam logic [CW:0] SIDE_M1 = (CW + 1)'(GRID_SIDE - 1);

  // Extents limited to grid
  logic [CW:0] ex, ey;
  assign ex = (32'(extent_x) > 32'(GRID_SIDE - 1)) ? SIDE_M1 : (CW + 1)'(extent_x);
  assign ey = (32'(extent_y) > 32'(GRID_SIDE - 1)) ? SIDE_M1 : (CW + 1)'(extent_y);

  // Grid memory ports
  logic            g_we;
  logic [AW-1:0]   g_wa, g_ra;
  logic [24:0]     g_wd, g_rd;
  gbp_ram #(.WIDTH(25), .DEPTH(GRID_SIDE * GRID_SIDE)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));

  // Queue memory
  logic            q_we;
  logic [AW-1:0]   q_wa, q_ra;
  logic [AW-1:0]   q_wd, q_rd;
  gbp_ram #(.WIDTH(AW), .DEPTH(GRID_SIDE * GRID_SIDE)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  logic [QW-1:0] head_r, tail_r;
  logic [QW-1:0] clr_r;      // clearing pass pointer
  logic [CW:0]   sx_r, sy_r; // scan position
  logic [CW-1:0] cx_r, cy_r; // popped cell
  logic [24:0]   pv_r;
  logic [24:0]   rd_r;

  // Neighbour coordinates of the popped cell
  logic [CW+1:0] nx_s, ny_s;
  logic [AW-1:0] n_addr;
  logic          nb_ok;
  always_comb begin
    nx_s = {2'b00, cx_r} + {{CW{gbp_pkg::NB_DX[ctl.nb][1]}}, gbp_pkg::NB_DX[ctl.nb]};
    ny_s = {2'b00, cy_r} + {{CW{gbp_pkg::NB_DY[ctl.nb][1]}}, gbp_pkg::NB_DY[ctl.nb]};
    nb_ok = !nx_s[CW+1] && !ny_s[CW+1] && (nx_s[CW:0] <= ex) && (ny_s[CW:0] <= ey);
    n_addr = {nx_s[CW-1:0], ny_s[CW-1:0]};
  end

  logic in_req, start_in, goal_in;
  assign in_req   = (32'(req_x) < 32'(GRID_SIDE)) && (32'(req_y) < 32'(GRID_SIDE));
  assign start_in = (32'(start_x) < 32'(GRID_SIDE)) && (32'(start_y) < 32'(GRID_SIDE));
  assign goal_in  = (32'(goal_x) < 32'(GRID_SIDE)) && (32'(goal_y) < 32'(GRID_SIDE));
  logic start_ext;
  assign start_ext = ((CW + 1)'(start_x) <= ex) && ((CW + 1)'(start_y) <= ey)
                     && start_in;

  logic [AW-1:0] req_a, start_a, goal_a, scan_a;
  assign req_a   = {CW'(req_x), CW'(req_y)};
  assign start_a = {CW'(start_x), CW'(start_y)};
  assign goal_a  = {CW'(goal_x), CW'(goal_y)};
  assign scan_a  = {sx_r[CW-1:0], sy_r[CW-1:0]};

  // Update of a visited cell
  logic [24:0] upd_val;
  logic        upd_en;
  always_comb begin
    upd_val = '0;
    upd_en  = 1'b0;
    if (!ctl.sel) begin
      upd_en  = (g_rd == '0);
      upd_val = gbp_pkg::V_REACH;
    end else if (g_rd == '0) begin
      upd_en  = 1'b1;
      upd_val = pv_r + gbp_pkg::V_STEP;
    end else if (g_rd == gbp_pkg::V_REACH) begin
      upd_en  = 1'b1;
      upd_val = (pv_r >= gbp_pkg::V_STEP + gbp_pkg::V_FLOOR) ?
                pv_r - gbp_pkg::V_STEP : gbp_pkg::V_FLOOR;
    end
  end

  // Memory port steering
  always_comb begin
    g_we = 1'b0; g_wa = req_a; g_wd = '0; g_ra = req_a;
    q_we = 1'b0; q_wa = tail_r[AW-1:0]; q_wd = n_addr; q_ra = head_r[AW-1:0];
    case (ctl.cmd)
      gbp_pkg::CMD_CLR_STEP: begin
        g_we = 1'b1; g_wa = clr_r[AW-1:0];
      end
      gbp_pkg::CMD_WR_CELL: begin
        g_we = in_req; g_wd = req_blk ? gbp_pkg::V_BLOCKED : '0;
      end
      gbp_pkg::CMD_CLR_SG: begin
        g_we = ctl.sel ? goal_in : start_in; g_wa = ctl.sel ? goal_a : start_a;
      end
      gbp_pkg::CMD_PUSH_START: begin
        q_we = start_ext; q_wd = start_a;
      end
      gbp_pkg::CMD_LOAD_CUR: g_ra = q_rd;
      gbp_pkg::CMD_NB_RD: g_ra = n_addr;
      gbp_pkg::CMD_NB_UPD: begin
        g_we = upd_en; g_wa = n_addr; g_wd = upd_val; q_we = upd_en;
      end
      gbp_pkg::CMD_SCAN_RD: g_ra = scan_a;
      gbp_pkg::CMD_SCAN_UPD: begin
        g_we = (g_rd == gbp_pkg::V_BLOCKED); g_wa = scan_a; g_wd = gbp_pkg::V_SEED;
        q_we = g_we; q_wd = scan_a;
      end
      default: ;
    endcase
  end

  // Pointers and latches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0; tail_r <= '0; clr_r <= '0; sx_r <= '0; sy_r <= '0;
    end else begin
      if (q_we) tail_r <= tail_r + 1'b1;
      case (ctl.cmd)
        gbp_pkg::CMD_CLR_STEP: clr_r <= clr_r + 1'b1;
        gbp_pkg::CMD_Q_RESET: begin
          head_r <= '0; tail_r <= '0; sx_r <= '0; sy_r <= '0;
        end
        gbp_pkg::CMD_POP: head_r <= head_r + 1'b1;
        gbp_pkg::CMD_SCAN_UPD: begin
          if (sy_r == ey) begin
            sy_r <= '0; sx_r <= sx_r + 1'b1;
          end else begin
            sy_r <= sy_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == gbp_pkg::CMD_LOAD_CUR) begin
      cx_r <= q_rd[AW-1:CW]; cy_r <= q_rd[CW-1:0];
    end
    if (ctl.cmd == gbp_pkg::CMD_LOAD_PV) pv_r <= g_rd;
    rd_r <= in_req ? g_rd : '0;
  end

  assign rd_value      = rd_r;
  assign sts.clr_last  = (clr_r[AW-1:0] == '1);
  assign sts.q_empty   = (head_r == tail_r);
  assign sts.nb_ok     = nb_ok;
  assign sts.scan_last = (sx_r == ex) && (sy_r == ey);
endmodule

// ----- src/gbp_ctrl.sv -----
module gbp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_done,
  output logic              out_is_rd,
  output gbp_pkg::gbp_ctl_t ctl,
  input  gbp_pkg::gbp_sts_t sts
);
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_CLR_S, S_CLR_G, S_QRST, S_PUSH,
    S_POP, S_CUR, S_PV, S_PV2, S_NBRD, S_NBUPD, S_SCRD, S_SCUPD, S_QRST2, S_OUT
  } state_t;

  state_t     state_r;
  logic       wave_r;
  logic [2:0] nb_r;
  logic       done_r, isrd_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_done  = done_r;
  assign out_is_rd = isrd_r;

  // Command decode
  always_comb begin
    ctl.cmd = gbp_pkg::CMD_NONE;
    ctl.sel = wave_r;
    ctl.nb  = nb_r;
    case (state_r)
      S_CLEAR: ctl.cmd = gbp_pkg::CMD_CLR_STEP;
      S_IDLE: begin
        if (in_valid && in_mode == gbp_pkg::MODE_WRITE) ctl.cmd = gbp_pkg::CMD_WR_CELL;
        else if (in_valid && in_mode == gbp_pkg::MODE_READ) ctl.cmd = gbp_pkg::CMD_RD_CELL;
      end
      S_CLR_S: begin ctl.cmd = gbp_pkg::CMD_CLR_SG; ctl.sel = 1'b0; end
      S_CLR_G: begin ctl.cmd = gbp_pkg::CMD_CLR_SG; ctl.sel = 1'b1; end
      S_QRST, S_QRST2: ctl.cmd = gbp_pkg::CMD_Q_RESET;
      S_PUSH: ctl.cmd = gbp_pkg::CMD_PUSH_START;
      S_POP: ctl.cmd = sts.q_empty ? gbp_pkg::CMD_NONE : gbp_pkg::CMD_POP;
      S_CUR: ctl.cmd = gbp_pkg::CMD_LOAD_CUR;
      S_PV: ctl.cmd = gbp_pkg::CMD_LOAD_PV;   // grid data of the popped cell is valid here
      S_NBRD: ctl.cmd = sts.nb_ok ? gbp_pkg::CMD_NB_RD : gbp_pkg::CMD_NONE;
      S_NBUPD: ctl.cmd = gbp_pkg::CMD_NB_UPD;
      S_SCRD: ctl.cmd = gbp_pkg::CMD_SCAN_RD;
      S_SCUPD: ctl.cmd = gbp_pkg::CMD_SCAN_UPD;
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; wave_r <= 1'b0; nb_r <= '0; done_r <= 1'b0; isrd_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: if (sts.clr_last) state_r <= S_IDLE;
        S_IDLE: begin
          if (in_valid) begin
            done_r <= (in_mode != gbp_pkg::MODE_NONE);
            isrd_r <= (in_mode == gbp_pkg::MODE_READ);
            case (in_mode)
              gbp_pkg::MODE_READ: state_r <= S_RD1;
              gbp_pkg::MODE_RUN: begin state_r <= S_CLR_S; wave_r <= 1'b0; end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_RD1: state_r <= S_RD2;
        S_RD2: state_r <= S_OUT;
        S_CLR_S: state_r <= S_CLR_G;
        S_CLR_G: state_r <= S_QRST;
        S_QRST: state_r <= S_PUSH;
        S_PUSH: state_r <= S_POP;
        S_POP: begin
          if (sts.q_empty) begin
            if (wave_r) state_r <= S_OUT;
            else begin wave_r <= 1'b1; state_r <= S_QRST2; end
          end else state_r <= S_CUR;
        end
        S_CUR: state_r <= S_PV;
        S_PV: state_r <= S_PV2;
        S_PV2: begin nb_r <= '0; state_r <= S_NBRD; end
        S_NBRD: begin
          if (sts.nb_ok) state_r <= S_NBUPD;
          else if (nb_r == 3'd7) state_r <= S_POP;
          else nb_r <= nb_r + 1'b1;
        end
        S_NBUPD: begin
          if (nb_r == 3'd7) state_r <= S_POP;
          else begin nb_r <= nb_r + 1'b1; state_r <= S_NBRD; end
        end
        S_QRST2: state_r <= S_SCRD;
        S_SCRD: state_r <= S_SCUPD;
        S_SCUPD: state_r <= sts.scan_last ? S_POP : S_SCRD;
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- src/grid_brushfire_potential_top.sv -----
// A read passes through S_RD1 and S_RD2 before its result is offered; write and mode 3 requests go straight to S_OUT.
// A run marks the cells reachable from the start, then floods values out from the blocked
// cells found by a scan of the extent; one request at a time.
// Reset: synchronous active low; afterwards a clearing pass over all GRID_SIDE*GRID_SIDE
// cells zeroes the grid before the first request is accepted.
module grid_brushfire_potential_top #(
  parameter int GRID_SIDE = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  gbp_in_if.sink     in_ch,
  gbp_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  logic [7:0] start_x_r, start_y_r, goal_x_r, goal_y_r, extent_x_r, extent_y_r;
  logic [7:0] req_x_r, req_y_r;
  logic       req_blk_r;
  gbp_pkg::gbp_ctl_t ctl;
  gbp_pkg::gbp_sts_t sts;
  logic [24:0] rd_value;
  logic        done, is_rd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0; start_y_r <= '0; goal_x_r <= '0; goal_y_r <= '0;
      extent_x_r <= 8'd255; extent_y_r <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        gbp_pkg::CFG_START_X:  start_x_r  <= cfg_data;
        gbp_pkg::CFG_START_Y:  start_y_r  <= cfg_data;
        gbp_pkg::CFG_GOAL_X:   goal_x_r   <= cfg_data;
        gbp_pkg::CFG_GOAL_Y:   goal_y_r   <= cfg_data;
        gbp_pkg::CFG_EXTENT_X: extent_x_r <= cfg_data;
        gbp_pkg::CFG_EXTENT_Y: extent_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_x_r <= in_ch.cell_x; req_y_r <= in_ch.cell_y; req_blk_r <= in_ch.blocked;
    end
  end

  gbp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_mode(in_ch.mode), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_done(done), .out_is_rd(is_rd), .ctl(ctl), .sts(sts));

  // Write and read commands are issued in the accept cycle, so use live fields there
  logic [7:0] dp_x, dp_y;
  logic       dp_blk;
  assign dp_x   = in_ch.ready ? in_ch.cell_x : req_x_r;
  assign dp_y   = in_ch.ready ? in_ch.cell_y : req_y_r;
  assign dp_blk = in_ch.ready ? in_ch.blocked : req_blk_r;

  gbp_datapath #(.GRID_SIDE(GRID_SIDE)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .req_x(dp_x), .req_y(dp_y), .req_blk(dp_blk),
    .start_x(start_x_r), .start_y(start_y_r), .goal_x(goal_x_r), .goal_y(goal_y_r),
    .extent_x(extent_x_r), .extent_y(extent_y_r), .rd_value(rd_value));

  assign out_ch.cell_value = is_rd ? rd_value : '0;
  assign out_ch.done_res   = done;
endmodule
